[design/ipv6fmt_pkg.sv]
`timescale 1ns / 1ps
package ipv6fmt_pkg;

    localparam int ADDR_W = 128;
    localparam int SLOTS = 64;          // 8 groups x 8 slots
    localparam int SLOT_W = 6;
    localparam int BCD_W = 48;          // 4 bytes x 3 digits x 4 bits

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT = 8'h2e;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_A = 8'h61;

    // Slot codes inside a normal group
    localparam logic [2:0] SL_PRE = 3'd0;
    localparam logic [2:0] SL_LOW = 3'd4;
    localparam logic [2:0] SL_SUF = 3'd5;
    // Slot codes inside a dotted-decimal byte
    localparam logic [1:0] DS_DOT = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              mapped;
        logic [SLOTS-1:0]  mask;
        logic [BCD_W-1:0]  bcd;
    } cmd_t;

endpackage

[design/ipv6fmt_front.sv]
`timescale 1ns / 1ps
module ipv6fmt_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [127:0]            in_addr,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output ipv6fmt_pkg::cmd_t       cmd
);

    logic         item_valid_reg;
    logic [127:0] addr_reg;

    function automatic logic [11:0] dec_digits(input logic [7:0] v);
        logic [1:0] h;
        logic [7:0] r;
        logic [3:0] t;
        logic [7:0] o;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = v - 8'(h * 8'd100);
        t = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r >= 8'(10 * k)) t = t + 4'd1;
        end
        o = r - 8'(t * 8'd10);
        dec_digits = {2'b00, h, t, o[3:0]};
    endfunction

    assign in_ready = !item_valid_reg || cmd_ready;
    assign cmd_valid = item_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (in_ready) begin
            item_valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            addr_reg <= in_addr;
        end
    end

    // classify: first zero run, v4-mapped prefix, emit mask
    always_comb begin
        logic [15:0] grp [8];
        logic [7:0]  zero;
        logic        started;
        logic        ended;
        logic [2:0]  rs;
        logic [2:0]  re;
        logic        mapped;
        logic        in_run;
        logic [7:0]  byte_v;
        logic [ipv6fmt_pkg::SLOTS-1:0] mask;
        logic [ipv6fmt_pkg::BCD_W-1:0] bcd;
        started = 1'b0;
        ended = 1'b0;
        rs = '0;
        re = '0;
        mask = '0;
        bcd = '0;
        mapped = (addr_reg[127:32] == {80'h0, 16'hffff});
        for (int i = 0; i < 8; i++) begin
            grp[i] = addr_reg[127-16*i -: 16];
            zero[i] = (grp[i] == 16'h0);
        end
        for (int i = 0; i < 8; i++) begin
            if (zero[i] && !ended) begin
                if (!started) rs = 3'(i);
                started = 1'b1;
                re = 3'(i);
            end else if (started) begin
                ended = 1'b1;
            end
        end
        for (int i = 0; i < 8; i++) begin
            in_run = started && (3'(i) >= rs) && (3'(i) <= re);
            if (!(mapped && i >= 6)) begin
                if (in_run) begin
                    mask[8*i]     = (i == 0);
                    mask[8*i + 5] = (i == 7);
                end else begin
                    mask[8*i] = started && ({1'b0, re} + 4'd1 == 4'(i));
                    for (int k = 0; k < 4; k++) begin
                        mask[8*i + 1 + k] = ((grp[i] >> (12 - 4*k)) != 16'h0) || (k == 3);
                    end
                    mask[8*i + 5] = (i < 7);
                end
            end
        end
        for (int b = 0; b < 4; b++) begin
            byte_v = addr_reg[31-8*b -: 8];
            bcd[12*b +: 12] = dec_digits(byte_v);
            if (mapped) begin
                mask[48 + 4*b]     = (byte_v >= 8'd100);
                mask[48 + 4*b + 1] = (byte_v >= 8'd10);
                mask[48 + 4*b + 2] = 1'b1;
                mask[48 + 4*b + 3] = (b < 3);
            end
        end
        cmd.addr = addr_reg;
        cmd.mapped = mapped;
        cmd.mask = mask;
        cmd.bcd = bcd;
    end

endmodule

[design/ipv6fmt_queue.sv]
`timescale 1ns / 1ps
module ipv6fmt_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  ipv6fmt_pkg::cmd_t  wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output ipv6fmt_pkg::cmd_t  rd_data
);

    ipv6fmt_pkg::cmd_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem[wr_ptr_reg] <= wr_data;
    end

endmodule

[design/ipv6fmt_back.sv]
`timescale 1ns / 1ps
module ipv6fmt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ipv6fmt_pkg::cmd_t  cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               out_last
);

    logic                          active_reg;
    logic [ipv6fmt_pkg::SLOTS-1:0] mask_reg;
    logic [127:0]                  addr_reg;
    logic                          mapped_reg;
    logic [ipv6fmt_pkg::BCD_W-1:0] bcd_reg;
    logic                          out_valid_reg;
    logic [7:0]                    char_reg;
    logic                          last_reg;

    logic [ipv6fmt_pkg::SLOT_W-1:0] slot;
    logic [ipv6fmt_pkg::SLOTS-1:0]  mask_next;
    logic                           emit;
    logic                           done;
    logic [7:0]                     ch;

    // lowest pending slot
    always_comb begin
        slot = '0;
        for (int s = ipv6fmt_pkg::SLOTS - 1; s >= 0; s--) begin
            if (mask_reg[s]) slot = ipv6fmt_pkg::SLOT_W'(s);
        end
    end

    always_comb begin
        logic [2:0]  g;
        logic [2:0]  p;
        logic [1:0]  b;
        logic [3:0]  nib;
        logic [15:0] grp;
        g = slot[5:3];
        p = slot[2:0];
        b = {g[0], p[2]};
        grp = addr_reg[8'd127 - {g, 4'd0} -: 16];
        nib = grp[15 - 4*(p[1:0] - 2'd1) -: 4];
        if (mapped_reg && g[2] && g[1]) begin
            if (p[1:0] == ipv6fmt_pkg::DS_DOT) begin
                ch = ipv6fmt_pkg::CH_DOT;
            end else begin
                ch = ipv6fmt_pkg::CH_ZERO + {4'd0, bcd_reg[12*b + 8 - 4*p[1:0] +: 4]};
            end
        end else if (p == ipv6fmt_pkg::SL_PRE || p == ipv6fmt_pkg::SL_SUF) begin
            ch = ipv6fmt_pkg::CH_COLON;
        end else begin
            if (p == ipv6fmt_pkg::SL_LOW) nib = grp[3:0];
            ch = (nib < 4'd10) ? ipv6fmt_pkg::CH_ZERO + {4'd0, nib}
                               : ipv6fmt_pkg::CH_A + {4'd0, nib - 4'd10};
        end
    end

    assign emit = active_reg && (!out_valid_reg || out_ready);
    assign mask_next = mask_reg & (mask_reg - 1'b1);
    assign done = emit && (mask_next == '0);
    assign cmd_ready = !active_reg || done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd_ready) begin
                active_reg <= cmd_valid;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd_valid && cmd_ready) begin
            mask_reg <= cmd.mask;
            addr_reg <= cmd.addr;
            mapped_reg <= cmd.mapped;
            bcd_reg <= cmd.bcd;
        end else if (emit) begin
            mask_reg <= mask_next;
        end
        if (emit) begin
            char_reg <= ch;
            last_reg <= (mask_next == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char = char_reg;
    assign out_last = last_reg;

    a_active_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (mask_reg != '0))
        else $error("active item has no pending slot");
    a_more_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !done) |=> active_reg)
        else $error("item dropped before its last character");
    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (out_valid_reg && last_reg))
        else $error("final character not flagged");

endmodule

[design/ipv6_address_text_formatter.sv]
`timescale 1ns / 1ps
// Channel   Dir  Signals                          Carries
// s_        in   s_tvalid s_tready s_tdata[127:0] one IPv6 address per request
// m_        out  m_tvalid m_tready m_tdata[7:0]   one ASCII character per request,
//                m_tlast                          m_tlast on the final character
//
// Each address yields 2 to 39 characters, one per cycle while m_tready is high;
// the back sequencer's single character per cycle sets the rate. The first
// character of an address passes the front register, queue and sequencer
// load on its way to m_.
// Reset (aresetn low, synchronous) empties the front register, queue and sequencer.
// The two-entry queue lets the front keep taking addresses while m_ stalls.
module ipv6_address_text_formatter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] addr_high, [127:64] addr_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [7:0] text_char
    output logic         m_tlast    // last_char
);

    ipv6fmt_pkg::cmd_t front_cmd;
    ipv6fmt_pkg::cmd_t back_cmd;
    logic front_valid;
    logic front_ready;
    logic back_valid;
    logic back_ready;

    ipv6fmt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_addr   ({s_tdata[63:0], s_tdata[127:64]}),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    ipv6fmt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_cmd)
    );

    ipv6fmt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         m_tlast;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic [127:0] addr_queue[$];     // addresses waiting to be offered
    text_char_t   text_queue[$];     // characters expected from the block
    int           mismatches = 0;
    bit           stim_done = 1'b0;
    bit           quiet = 1'b0;      // last part of run: no idling
    int           s_gap = 0;
    int           m_gap = 0;
    int           hold_cnt = 0;      // long receiver hold-off, own counter

    ipv6_address_text_formatter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h61 + {4'd0, n} - 8'd10;
    endfunction

    task automatic push_char(input logic [7:0] c);
        text_char_t t;
        t.ch = c;
        t.last = 1'b0;
        text_queue.push_back(t);
    endtask

    task automatic push_hex(input logic [15:0] v);
        bit started;
        started = 0;
        for (int sh = 12; sh >= 0; sh -= 4) begin
            if (v[sh+:4] != 0 || started || sh == 0) begin
                push_char(hex_digit(v[sh+:4]));
                started = 1;
            end
        end
    endtask

    task automatic push_dec(input logic [7:0] v);
        if (v >= 100) push_char(8'(8'h30 + v / 100));
        if (v >= 10) push_char(8'(8'h30 + (v / 10) % 10));
        push_char(8'(8'h30 + v % 10));
    endtask

    // Expected text for one address. s_tdata[63:0] = high half (bytes 0..7).
    task automatic predict_text(input logic [127:0] word);
        logic [63:0] hi, lo;
        logic [15:0] grp[8];
        bit mapped, in_run, run_done;
        text_char_t t;
        hi = word[63:0];
        lo = word[127:64];
        mapped = (hi == 0) && (lo[63:32] == 32'hffff);
        in_run = 0;
        run_done = 0;
        for (int i = 0; i < 4; i++) begin
            grp[i] = hi[48-16*i +: 16];
            grp[i+4] = lo[48-16*i +: 16];
        end
        for (int i = 0; i < 8; i++) begin
            if (i == 6 && mapped) begin
                push_dec(lo[31:24]); push_char(8'h2e);
                push_dec(lo[23:16]); push_char(8'h2e);
                push_dec(lo[15:8]);  push_char(8'h2e);
                push_dec(lo[7:0]);
                break;
            end
            if (grp[i] == 0 && !run_done) begin
                if (!in_run) begin
                    in_run = 1;
                    if (i == 0) push_char(8'h3a);
                end
            end else begin
                if (in_run) begin
                    in_run = 0;
                    run_done = 1;
                    push_char(8'h3a);
                end
                push_hex(grp[i]);
                if (i < 7) push_char(8'h3a);
            end
        end
        if (in_run) push_char(8'h3a);
        t = text_queue.pop_back();
        t.last = 1'b1;
        text_queue.push_back(t);
    endtask

    function automatic logic [127:0] pack_addr(input logic [63:0] hi, input logic [63:0] lo);
        return {lo, hi};
    endfunction

    // Random group: often zero or small so runs and short hex appear often.
    function automatic logic [15:0] rand_group();
        case ($urandom_range(0, 5))
            0, 1: return 16'h0;
            2: return 16'($urandom_range(1, 15));
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [63:0] hi, lo;
        // directed: extremes, zero-run placement, v4-mapped forms
        addr_queue.push_back(pack_addr(64'h0, 64'h0));
        addr_queue.push_back(pack_addr('1, '1));
        addr_queue.push_back(pack_addr(64'h0, 64'h1));
        addr_queue.push_back(pack_addr(64'h0001_0000_0000_0000, 64'h0));
        addr_queue.push_back(pack_addr(64'h0001_0000_0002_0000, 64'h0000_0003_0000_0004));
        addr_queue.push_back(pack_addr(64'h2001_0db8_0000_0000, 64'h0000_ff00_0042_8329));
        addr_queue.push_back(pack_addr(64'h0, 64'h0000_ffff_0000_0000));
        addr_queue.push_back(pack_addr(64'h0, 64'h0000_ffff_ffff_ffff));
        addr_queue.push_back(pack_addr(64'h0, 64'h0000_ffff_c0a8_0109));
        addr_queue.push_back(pack_addr(64'h0, 64'h0000_ffff_0a63_6409));
        addr_queue.push_back(pack_addr(64'h0, 64'h0000_fffe_0102_0304));
        addr_queue.push_back(pack_addr(64'h0, 64'h0001_ffff_0102_0304));
        addr_queue.push_back(pack_addr(64'h1, 64'h0000_ffff_0102_0304));
        addr_queue.push_back(pack_addr(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210));
        addr_queue.push_back(pack_addr(64'h1000_0100_0010_0001, 64'h0000_0000_0000_0001));
        addr_queue.push_back(pack_addr(64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa));
        for (int k = 0; k < 200; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    hi = {$urandom, $urandom};
                    lo = {$urandom, $urandom};
                end
                1, 2: begin
                    hi = 64'h0;
                    lo = {32'h0000_ffff, $urandom};
                end
                default: begin
                    hi = {rand_group(), rand_group(), rand_group(), rand_group()};
                    lo = {rand_group(), rand_group(), rand_group(), rand_group()};
                end
            endcase
            addr_queue.push_back(pack_addr(hi, lo));
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: predicts on acceptance, then offers the next address.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_text(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    s_gap <= $urandom_range(1, 16) - 1;
                    s_tvalid <= 1'b0;
                end else if (addr_queue.size() > 0) begin
                    s_tdata <= addr_queue.pop_front();
                    s_tvalid <= 1'b1;
                    if (addr_queue.size() < 40) quiet <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted character, then sets m_tready.
    always @(posedge aclk) begin
        text_char_t exp_c;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (text_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected char %h last %b", m_tdata, m_tlast);
                end else begin
                    exp_c = text_queue.pop_front();
                    if (exp_c.ch !== m_tdata || exp_c.last !== m_tlast) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("char mismatch: exp %h last %b, got %h last %b",
                                     exp_c.ch, exp_c.last, m_tdata, m_tlast);
                    end
                end
            end
            if (hold_cnt < 400) begin
                // long hold-off early on so the queue fills and s_tready drops
                hold_cnt <= hold_cnt + 1;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_gap <= $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (aresetn);
        wait (addr_queue.size() == 0);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        while (text_queue.size() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && text_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

[ipv6_address_text_formatter.f]
design/ipv6fmt_pkg.sv
design/ipv6fmt_front.sv
design/ipv6fmt_queue.sv
design/ipv6fmt_back.sv
design/ipv6_address_text_formatter.sv
tb/testbench.sv
